[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active-low reset).
`define ASSERT_CLKD(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

[hw/rtl/xtea_pkg.sv]
// Package: XTEA constants, pipeline stage type and per-cell round constants.
package xtea_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ROUNDS    = 32;

  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3
  } xtea_reg_e;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
  } xtea_stage_t;

  // Running sum seen by half-round h (even: before the add of delta, odd: after).
  function automatic logic [WORD_W-1:0] half_sum(int unsigned h);
    logic [WORD_W-1:0] n;
    n = WORD_W'((h + 1) >> 1);
    return n * DELTA;
  endfunction

  // Key word used by half-round h.
  function automatic logic [1:0] key_sel(int unsigned h);
    logic [WORD_W-1:0] s;
    s = half_sum(h);
    if (h[0]) begin
      return s[12:11];
    end
    return s[1:0];
  endfunction

endpackage

[hw/rtl/xtea_block_encrypt_core.sv]
// Top level: XTEA encryption as a chain of half-round cells with key registers.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   in       | in_valid_i / in_ready_o | first_word_i, second_word_i
//   out      | out_valid_o/out_ready_i | cipher_first_word_o, cipher_second_word_o
//   cfg      | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One item per cycle while the output does not stall the chain; each item passes
// one cell per half-round, then the output register.
// Reset clears all valid bits and the key to zero.
// A held output stalls the chain only when the last cell holds an item;
// bubbles in the chain keep moving, so input is taken while a result waits.
module xtea_block_encrypt_core #(
  parameter int unsigned ROUNDS = xtea_pkg::ROUNDS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [xtea_pkg::WORD_W-1:0]    first_word_i,
  input  logic [xtea_pkg::WORD_W-1:0]    second_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [xtea_pkg::WORD_W-1:0]    cipher_first_word_o,
  output logic [xtea_pkg::WORD_W-1:0]    cipher_second_word_o,
  input  logic                           cfg_we_i,
  input  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [xtea_pkg::WORD_W-1:0]    cfg_data_i
);
  import xtea_pkg::*;

  localparam int unsigned CELLS = 2 * ROUNDS;

  key_t        key_q;
  xtea_stage_t stage [CELLS+1];
  logic        advance, out_load;
  logic        out_valid_q;
  logic [WORD_W-1:0] out_w0_q, out_w1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY0: key_q[0] <= cfg_data_i;
        REG_KEY1: key_q[1] <= cfg_data_i;
        REG_KEY2: key_q[2] <= cfg_data_i;
        REG_KEY3: key_q[3] <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  assign out_load   = !out_valid_q || out_ready_i;
  assign advance    = out_load || !stage[CELLS].valid;
  assign in_ready_o = advance;

  assign stage[0] = '{valid: in_valid_i && advance, w0: first_word_i, w1: second_word_i};

  for (genvar h = 0; h < CELLS; h++) begin : g_cell
    xtea_cell #(
      .HALF(h)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .key_i  (key_q),
      .stage_i(stage[h]),
      .stage_o(stage[h+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= stage[CELLS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_w0_q <= stage[CELLS].w0;
      out_w1_q <= stage[CELLS].w1;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign cipher_first_word_o  = out_w0_q;
  assign cipher_second_word_o = out_w1_q;

endmodule

[hw/rtl/xtea_cell.sv]
// One XTEA half-round as a registered pipeline cell.
module xtea_cell #(
  parameter int unsigned HALF = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  xtea_pkg::key_t       key_i,
  input  xtea_pkg::xtea_stage_t stage_i,
  output xtea_pkg::xtea_stage_t stage_o
);
  import xtea_pkg::*;

  localparam logic [WORD_W-1:0] SUM    = half_sum(HALF);
  localparam logic [1:0]        KSEL   = key_sel(HALF);
  localparam bit                IS_ODD = (HALF % 2) == 1;

  logic              valid_q;
  logic [WORD_W-1:0] w0_q, w0_d;
  logic [WORD_W-1:0] w1_q, w1_d;
  logic [WORD_W-1:0] src, mix, rkey;

  always_comb begin
    src  = IS_ODD ? stage_i.w0 : stage_i.w1;
    mix  = ((src << 4) ^ (src >> 5)) + src;
    rkey = SUM + key_i[KSEL];
    w0_d = stage_i.w0;
    w1_d = stage_i.w1;
    if (IS_ODD) begin
      w1_d = stage_i.w1 + (mix ^ rkey);
    end else begin
      w0_d = stage_i.w0 + (mix ^ rkey);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w0_q <= w0_d;
      w1_q <= w1_d;
    end
  end

  assign stage_o = '{valid: valid_q, w0: w0_q, w1: w1_q};

endmodule

[hw/rtl/xtea_checker.sv]
// Port-level checker for the XTEA core, bound to the top level.
`include "assert_macros.svh"

module xtea_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [xtea_pkg::WORD_W-1:0]    cipher_first_word_o,
  input logic [xtea_pkg::WORD_W-1:0]    cipher_second_word_o
);

  logic held;

  assign held = out_valid_o && !out_ready_i;

  // A stalled result stays up.
  `ASSERT_CLKD(a_out_hold, clk_i, rst_ni, held |=> out_valid_o)

  // A stalled result keeps its payload.
  `ASSERT_CLKD(a_first_stable, clk_i, rst_ni, held |=> $stable(cipher_first_word_o))
  `ASSERT_CLKD(a_second_stable, clk_i, rst_ni, held |=> $stable(cipher_second_word_o))

  // Input is refused only while a result is held back.
  `ASSERT_ALWAYS(a_ready_cause, clk_i, !in_ready_o |-> out_valid_o && !out_ready_i)

  // No result in the cycle right after reset is released.
  `ASSERT_ALWAYS(a_reset_empty, clk_i, $rose(rst_ni) |-> !out_valid_o)

endmodule

bind xtea_block_encrypt_core xtea_checker u_xtea_checker (.*);

[dv/xtea_block_encrypt_core_tb.sv]
// Testbench for xtea_block_encrypt_core: predicts each cipher block and checks every result.
`timescale 1ns / 1ps

module xtea_block_encrypt_core_tb;
  import xtea_pkg::*;

  localparam int unsigned LATENCY          = 2 * ROUNDS + 1;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned CYCLE_LIMIT      = 200_000;
  localparam int unsigned FIRST_UNUSED_IDX = KEY_WORDS;
  localparam int unsigned LAST_IDX         = 2 ** CFG_IDX_W - 1;
  localparam int unsigned RANDOM_PHASES    = 6;
  localparam int unsigned BLOCKS_PER_PHASE = 250;
  localparam int unsigned STALL_BLOCKS     = 150;

  typedef struct {
    logic [WORD_W-1:0] plain0;
    logic [WORD_W-1:0] plain1;
    logic [WORD_W-1:0] c0;
    logic [WORD_W-1:0] c1;
  } cipher_t;

  typedef struct {
    logic [CFG_IDX_W-1:0] idx;
    logic [WORD_W-1:0]    data;
  } reg_write_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [WORD_W-1:0]    first_word_i;
  logic [WORD_W-1:0]    second_word_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [WORD_W-1:0]    cipher_first_word_o;
  logic [WORD_W-1:0]    cipher_second_word_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [WORD_W-1:0]    cfg_data_i;

  logic [WORD_W-1:0] key_copy [KEY_WORDS];
  cipher_t           pending_ciphers [$];
  int unsigned       mismatches;
  int unsigned       cycles;
  int unsigned       burst_left;
  bit                steady_send;
  int unsigned       holds_requested;

  xtea_block_encrypt_core dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .first_word_i        (first_word_i),
    .second_word_i       (second_word_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .cipher_first_word_o (cipher_first_word_o),
    .cipher_second_word_o(cipher_second_word_o),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("xtea_block_encrypt_core_tb: errors");
      $finish;
    end
  end

  function automatic cipher_t encipher(input logic [WORD_W-1:0] p0, input logic [WORD_W-1:0] p1);
    cipher_t           res;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] s;
    v0 = p0;
    v1 = p1;
    s  = '0;
    for (int r = 0; r < ROUNDS; r++) begin
      v0 += (((v1 << 4) ^ (v1 >> 5)) + v1) ^ (s + key_copy[s[1:0]]);
      s  += DELTA;
      v1 += (((v0 << 4) ^ (v0 >> 5)) + v0) ^ (s + key_copy[s[12:11]]);
    end
    res.plain0 = p0;
    res.plain1 = p1;
    res.c0     = v0;
    res.c1     = v1;
    return res;
  endfunction

  // Biased toward zero, all ones, one-hot, one-cold and small values.
  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = '1;
      2:       w = WORD_W'(1) << $urandom_range(0, WORD_W - 1);
      3:       w = ~(WORD_W'(1) << $urandom_range(0, WORD_W - 1));
      4:       w = WORD_W'($urandom_range(0, 255));
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic send_block(input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1);
    int unsigned gap;
    if (!steady_send && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_valid_i    <= 1'b1;
    first_word_i  <= w0;
    second_word_i <= w1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_ciphers.push_back(encipher(w0, w1));
    if (burst_left > 0) burst_left--;
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_ciphers.size() != 0);
  endtask

  task automatic write_regs(input reg_write_t writes [$]);
    foreach (writes[i]) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= writes[i].idx;
      cfg_data_i <= writes[i].data;
      @(posedge clk_i);
      if (writes[i].idx < KEY_WORDS) key_copy[writes[i].idx] = writes[i].data;
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                         input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
    reg_write_t writes [$];
    writes.push_back('{REG_KEY0, k0});
    writes.push_back('{REG_KEY1, k1});
    writes.push_back('{REG_KEY2, k2});
    writes.push_back('{REG_KEY3, k3});
    write_regs(writes);
  endtask

  task automatic test_reset_key();
    send_block('0, '0);
    send_block('1, '1);
    send_block('0, '1);
    send_block('1, '0);
    send_block(32'h8000_0000, 32'h0000_0001);
    wait_drain();
  endtask

  task automatic test_key_extremes();
    set_key('1, '1, '1, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block($urandom, $urandom);
    wait_drain();
    set_key('0, '1, '0, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block($urandom, $urandom);
    wait_drain();
    set_key(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
    send_block('0, '0);
    send_block(32'hDEAD_BEEF, 32'hCAFE_F00D);
    send_block($urandom, $urandom);
    wait_drain();
  endtask

  // Writes above the last key register must leave the key untouched.
  task automatic test_unused_index();
    reg_write_t writes [$];
    set_key($urandom, $urandom, $urandom, $urandom);
    for (int unsigned i = FIRST_UNUSED_IDX; i <= LAST_IDX; i++) begin
      writes.push_back('{CFG_IDX_W'(i), $urandom});
      writes.push_back('{CFG_IDX_W'(i), '1});
    end
    write_regs(writes);
    send_block('0, '0);
    send_block('1, '1);
    send_block($urandom, $urandom);
    send_block($urandom, $urandom);
    wait_drain();
  endtask

  task automatic test_random_blocks();
    reg_write_t writes [$];
    reg_write_t w;
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      writes.delete();
      for (int unsigned k = 0; k < KEY_WORDS; k++) begin
        if (ph == 0 || $urandom_range(0, 2) != 0) writes.push_back('{CFG_IDX_W'(k), pick_word()});
      end
      if ($urandom_range(0, 1) == 1) begin
        w.idx  = CFG_IDX_W'($urandom_range(FIRST_UNUSED_IDX, LAST_IDX));
        w.data = $urandom;
        writes.insert($urandom_range(0, writes.size()), w);
      end
      write_regs(writes);
      repeat (BLOCKS_PER_PHASE) send_block(pick_word(), pick_word());
      wait_drain();
    end
  endtask

  // Output held off while input keeps coming, so the chain fills and input stalls.
  task automatic test_output_backpressure();
    set_key($urandom, $urandom, $urandom, $urandom);
    steady_send = 1'b1;
    holds_requested++;
    repeat (STALL_BLOCKS) send_block($urandom, $urandom);
    steady_send = 1'b0;
    wait_drain();
  endtask

  initial begin
    int unsigned holds_served;
    int unsigned hold;
    int unsigned window;
    int unsigned mode;
    int unsigned tick;
    holds_served = 0;
    hold         = 0;
    window       = 0;
    mode         = 0;
    tick         = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (holds_served != holds_requested) begin
        holds_served++;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        if (window == 0) begin
          mode   = $urandom_range(0, 3);
          window = $urandom_range(16, 96);
        end
        window--;
        tick++;
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= (tick % 4 == 0);
          default: out_ready_i <= ($urandom_range(0, 15) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cipher_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_ciphers.size() == 0) begin
        $error("unexpected item: cipher_first_word %h cipher_second_word %h",
               cipher_first_word_o, cipher_second_word_o);
        mismatches++;
      end else begin
        want = pending_ciphers.pop_front();
        if (cipher_first_word_o !== want.c0) begin
          $error("cipher_first_word: expected %h, got %h (plain %h %h)",
                 want.c0, cipher_first_word_o, want.plain0, want.plain1);
          mismatches++;
        end
        if (cipher_second_word_o !== want.c1) begin
          $error("cipher_second_word: expected %h, got %h (plain %h %h)",
                 want.c1, cipher_second_word_o, want.plain0, want.plain1);
          mismatches++;
        end
      end
    end
  end

  initial begin
    mismatches      = 0;
    cycles          = 0;
    burst_left      = 0;
    steady_send     = 1'b0;
    holds_requested = 0;
    foreach (key_copy[i]) key_copy[i] = '0;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    first_word_i  <= '0;
    second_word_i <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_key();
    test_key_extremes();
    test_unused_index();
    test_random_blocks();
    test_output_backpressure();

    repeat (LATENCY) @(posedge clk_i);
    if (mismatches == 0 && pending_ciphers.size() == 0) begin
      $display("xtea_block_encrypt_core_tb: clean");
    end else begin
      $display("xtea_block_encrypt_core_tb: errors");
    end
    $finish;
  end

endmodule
